@@ rtl/redo_log_transaction_tracker_defines.svh @@
// ----------------------------------------------------------------------------
// Redo log transaction tracker assertion macros
// Clocked assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef REDO_LOG_TRANSACTION_TRACKER_DEFINES_SVH
`define REDO_LOG_TRANSACTION_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Assert a property on an explicit clock, masked while reset is low
`define RLT_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
    else $error(msg);
// Assert a property on the module's clk and rst_n
`define RLT_ASSERT(label, prop, msg) \
  `RLT_ASSERT_CLK(label, clk, rst_n, prop, msg)
`else
`define RLT_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg)
`define RLT_ASSERT(label, prop, msg)
`endif

`endif

@@ rtl/rlt_pkg.sv @@
// ----------------------------------------------------------------------------
// Redo log transaction tracker package
// Field widths, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package rlt_pkg;

  // Payload widths
  localparam int OP_W         = 2;
  localparam int BLK_W        = 32;
  localparam int STATUS_W     = 3;
  localparam int CMD_W        = 3;
  localparam int CNT_W        = 5;
  localparam int ACT_W        = 4;
  localparam int LOG_BLOCKS_W = 16;
  localparam int CFG_IDX_W    = 1;

  // Parameter defaults
  localparam int LOG_ENTRIES_DEF   = 30;
  localparam int BLOCKS_PER_OP_DEF = 10;

  // Register reset values
  localparam logic [BLK_W-1:0]        LOG_START_RST  = BLK_W'(2);
  localparam logic [LOG_BLOCKS_W-1:0] LOG_BLOCKS_RST = LOG_BLOCKS_W'(31);

  // Highest count of outstanding operations
  localparam logic [ACT_W-1:0] ACT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN = 2'd0,
    OP_END   = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_WAIT         = 3'd1,
    ST_TOO_BIG      = 3'd2,
    ST_OUTSIDE      = 3'd3,
    ST_END_NO_BEGIN = 3'd4
  } status_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE    = 3'd0,
    CMD_COPY    = 3'd1,
    CMD_HEADER  = 3'd2,
    CMD_INSTALL = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG_START  = 1'd0,
    CFG_LOG_BLOCKS = 1'd1
  } cfg_reg_t;

  // Which kind of result the datapath builds on a load
  typedef enum logic [2:0] {
    RES_STATUS,
    RES_COPY,
    RES_HEADER,
    RES_INSTALL,
    RES_CLEAR
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    load;
    res_t    res_sel;
    status_t status;
    logic    pin;
    logic    last;
    logic    inc_active;
    logic    dec_active;
    logic    append;
    logic    clear_entries;
    logic    idx_inc;
    logic    idx_clr;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic begin_full;
    logic room_full;
    logic active_zero;
    logic active_one;
    logic entries_zero;
    logic idx_at_end;
    logic idx_last;
    logic hit;
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/rlt_intf.sv @@
// ----------------------------------------------------------------------------
// Redo log transaction tracker channel interfaces
// Valid/ready channels for operations, results and configuration writes.
// ----------------------------------------------------------------------------
interface rlt_in_if;
  import rlt_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [BLK_W-1:0] block_number;

  modport source (output valid, operation, block_number, input ready);
  modport sink   (input valid, operation, block_number, output ready);
endinterface

interface rlt_out_if;
  import rlt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CMD_W-1:0]    command;
  logic [BLK_W-1:0]    source_block;
  logic [BLK_W-1:0]    dest_block;
  logic [CNT_W-1:0]    header_count;
  logic                pin_request;
  logic                last;

  modport source (output valid, status, command, source_block, dest_block,
                  header_count, pin_request, last, input ready);
  modport sink   (input valid, status, command, source_block, dest_block,
                  header_count, pin_request, last, output ready);
endinterface

interface rlt_cfg_if;
  import rlt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BLK_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/rlt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Redo log transaction tracker controller
// Sequences decode, absorption search and the commit run over the datapath.
// ----------------------------------------------------------------------------
module rlt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rlt_pkg::dp_sts_t sts,
  output rlt_pkg::dp_cmd_t cmd
);
  import rlt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_COPY,
    S_HEADER,
    S_INSTALL,
    S_CLEAR
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Take a new transaction only between items
  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.res_sel = RES_STATUS;
    cmd.status  = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_BEGIN: begin
            if (sts.out_free) begin
              cmd.load = 1'b1;
              cmd.last = 1'b1;
              if (sts.begin_full) begin
                cmd.status = ST_WAIT;
              end else begin
                cmd.inc_active = 1'b1;
              end
              state_nxt = S_IDLE;
            end
          end
          OP_WRITE: begin
            if (!sts.room_full && !sts.active_zero) begin
              state_nxt = S_SEARCH;
            end else if (sts.out_free) begin
              cmd.load   = 1'b1;
              cmd.last   = 1'b1;
              cmd.status = sts.room_full ? ST_TOO_BIG : ST_OUTSIDE;
              state_nxt  = S_IDLE;
            end
          end
          OP_END: begin
            if (!sts.active_zero && sts.active_one && !sts.entries_zero) begin
              // Last end of a nonempty transaction: start the commit run
              cmd.dec_active = 1'b1;
              state_nxt      = S_COPY;
            end else if (sts.out_free) begin
              cmd.load = 1'b1;
              cmd.last = 1'b1;
              if (sts.active_zero) begin
                cmd.status = ST_END_NO_BEGIN;
              end else begin
                cmd.dec_active = 1'b1;
              end
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (sts.out_free) begin
              cmd.load  = 1'b1;
              cmd.last  = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_SEARCH: begin
        // Walk one logged slot per cycle; miss appends, hit absorbs
        if (sts.idx_at_end) begin
          if (sts.out_free) begin
            cmd.load   = 1'b1;
            cmd.last   = 1'b1;
            cmd.pin    = 1'b1;
            cmd.append = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (sts.hit) begin
          if (sts.out_free) begin
            cmd.load  = 1'b1;
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_COPY: begin
        if (sts.out_free) begin
          cmd.load    = 1'b1;
          cmd.res_sel = RES_COPY;
          cmd.idx_inc = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_HEADER;
          end
        end
      end
      S_HEADER: begin
        if (sts.out_free) begin
          cmd.load    = 1'b1;
          cmd.res_sel = RES_HEADER;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_INSTALL;
        end
      end
      S_INSTALL: begin
        if (sts.out_free) begin
          cmd.load    = 1'b1;
          cmd.res_sel = RES_INSTALL;
          cmd.idx_inc = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        if (sts.out_free) begin
          cmd.load          = 1'b1;
          cmd.res_sel       = RES_CLEAR;
          cmd.last          = 1'b1;
          cmd.clear_entries = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/rlt_dp.sv @@
// ----------------------------------------------------------------------------
// Redo log transaction tracker datapath
// Configuration, counters, logged block memory and the result register.
// ----------------------------------------------------------------------------
`include "redo_log_transaction_tracker_defines.svh"

module rlt_dp #(
  parameter int LOG_ENTRIES   = rlt_pkg::LOG_ENTRIES_DEF,
  parameter int BLOCKS_PER_OP = rlt_pkg::BLOCKS_PER_OP_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rlt_pkg::OP_W-1:0]   in_operation,
  input  logic [rlt_pkg::BLK_W-1:0]  in_block_number,
  rlt_cfg_if.sink                    cfg_ch,
  rlt_out_if.source                  out_ch,
  input  rlt_pkg::dp_cmd_t           cmd,
  output rlt_pkg::dp_sts_t           sts
);
  import rlt_pkg::*;

  localparam int AW     = $clog2(LOG_ENTRIES);
  localparam int NEED_W = $clog2((2 ** ACT_W) * BLOCKS_PER_OP + LOG_ENTRIES + 1);

  // Configuration
  logic [BLK_W-1:0]        log_start_r;
  logic [LOG_BLOCKS_W-1:0] log_blocks_r;

  // Transaction state
  logic [CNT_W-1:0] entry_count_r;
  logic [CNT_W-1:0] entry_count_nxt;
  logic [ACT_W-1:0] active_r;
  logic [ACT_W-1:0] active_nxt;

  // Current item and slot walk
  op_t              op_r;
  logic [BLK_W-1:0] blk_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] idx_nxt;

  // Logged home blocks in slot order
  logic [BLK_W-1:0] logged_blocks_r [LOG_ENTRIES];
  logic [BLK_W-1:0] rdata_r;

  // Result register
  logic             out_valid_r;
  status_t          out_status_r;
  cmd_t             out_command_r;
  logic [BLK_W-1:0] out_source_r;
  logic [BLK_W-1:0] out_dest_r;
  logic [CNT_W-1:0] out_hcount_r;
  logic             out_pin_r;
  logic             out_last_r;

  // Assembled result
  cmd_t             res_command;
  logic [BLK_W-1:0] res_source;
  logic [BLK_W-1:0] res_dest;
  logic [CNT_W-1:0] res_hcount;

  logic                    out_free;
  logic [BLK_W-1:0]        slot_blk;
  logic [LOG_BLOCKS_W-1:0] cap;
  logic [NEED_W-1:0]       need;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_start_r  <= LOG_START_RST;
      log_blocks_r <= LOG_BLOCKS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_LOG_START:  log_start_r  <= cfg_ch.data;
        CFG_LOG_BLOCKS: log_blocks_r <= cfg_ch.data[LOG_BLOCKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Admission and room checks
  assign need = NEED_W'(entry_count_r)
              + NEED_W'({1'b0, active_r} + (ACT_W + 1)'(1)) * NEED_W'(BLOCKS_PER_OP);
  assign cap  = (log_blocks_r == '0) ? '0 : log_blocks_r - LOG_BLOCKS_W'(1);
  assign slot_blk = log_start_r + BLK_W'(idx_r) + BLK_W'(1);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    sts              = '0;
    sts.op           = op_r;
    sts.begin_full   = (active_r == ACT_MAX) || (need > NEED_W'(LOG_ENTRIES));
    sts.room_full    = (entry_count_r >= CNT_W'(LOG_ENTRIES))
                    || (LOG_BLOCKS_W'(entry_count_r) >= cap);
    sts.active_zero  = (active_r == '0);
    sts.active_one   = (active_r == ACT_W'(1));
    sts.entries_zero = (entry_count_r == '0);
    sts.idx_at_end   = (idx_r == entry_count_r);
    sts.idx_last     = ((idx_r + CNT_W'(1)) == entry_count_r);
    sts.hit          = (rdata_r == blk_r);
    sts.out_free     = out_free;
  end

  // Counters and slot index
  always_comb begin
    entry_count_nxt = entry_count_r;
    if (cmd.clear_entries) begin
      entry_count_nxt = '0;
    end else if (cmd.append) begin
      entry_count_nxt = entry_count_r + CNT_W'(1);
    end
    active_nxt = active_r;
    if (cmd.inc_active) begin
      active_nxt = active_r + ACT_W'(1);
    end else if (cmd.dec_active) begin
      active_nxt = active_r - ACT_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.capture || cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      active_r      <= '0;
      idx_r         <= '0;
    end else begin
      entry_count_r <= entry_count_nxt;
      active_r      <= active_nxt;
      idx_r         <= idx_nxt;
    end
  end

  // Latch the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op_t'(in_operation);
      blk_r <= in_block_number;
    end
  end

  // Memory: append at the fill count, read ahead at the next slot index
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      logged_blocks_r[entry_count_r[AW-1:0]] <= blk_r;
    end
    rdata_r <= logged_blocks_r[idx_nxt[AW-1:0]];
  end

  // Build the result fields
  always_comb begin
    res_command = CMD_NONE;
    res_source  = '0;
    res_dest    = '0;
    res_hcount  = '0;
    case (cmd.res_sel)
      RES_COPY: begin
        res_command = CMD_COPY;
        res_source  = rdata_r;
        res_dest    = slot_blk;
      end
      RES_HEADER: begin
        res_command = CMD_HEADER;
        res_dest    = log_start_r;
        res_hcount  = entry_count_r;
      end
      RES_INSTALL: begin
        res_command = CMD_INSTALL;
        res_source  = slot_blk;
        res_dest    = rdata_r;
      end
      RES_CLEAR: begin
        res_command = CMD_CLEAR;
        res_dest    = log_start_r;
      end
      default: ;
    endcase
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r  <= cmd.status;
      out_command_r <= res_command;
      out_source_r  <= res_source;
      out_dest_r    <= res_dest;
      out_hcount_r  <= res_hcount;
      out_pin_r     <= cmd.pin;
      out_last_r    <= cmd.last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.command      = out_command_r;
  assign out_ch.source_block = out_source_r;
  assign out_ch.dest_block   = out_dest_r;
  assign out_ch.header_count = out_hcount_r;
  assign out_ch.pin_request  = out_pin_r;
  assign out_ch.last         = out_last_r;

  `RLT_ASSERT(a_count_bound, entry_count_r <= CNT_W'(LOG_ENTRIES), "entry count past log size")
  `RLT_ASSERT(a_load_free, cmd.load |-> out_free, "result loaded over a pending one")
  `RLT_ASSERT(a_append_room, cmd.append |-> !sts.room_full && !sts.active_zero, "append without room or operation")
  `RLT_ASSERT(a_no_underflow, cmd.dec_active |-> active_r != '0, "operation count underflow")

endmodule

@@ rtl/redo_log_transaction_tracker.sv @@
// ----------------------------------------------------------------------------
// Redo log transaction tracker
// Group-commit redo log bookkeeping with begin, log write and end operations.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time; in_ch.ready is high only between
// transactions. A log write that is admitted walks the logged block memory
// through its single read port, one slot per cycle, until the block is found
// and absorbed or the end of the log is reached and the new block appended.
// The last end of a nonempty transaction emits 2 * entry_count + 2 results,
// one per cycle while the sink is ready. A finished result waits in the output
// register while the next transaction is already accepted.
module redo_log_transaction_tracker #(
  parameter int LOG_ENTRIES   = rlt_pkg::LOG_ENTRIES_DEF,
  parameter int BLOCKS_PER_OP = rlt_pkg::BLOCKS_PER_OP_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rlt_in_if.sink    in_ch,
  rlt_out_if.source out_ch,
  rlt_cfg_if.sink   cfg_ch
);
  import rlt_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer
  rlt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // State, memory and result register
  rlt_dp #(
    .LOG_ENTRIES   (LOG_ENTRIES),
    .BLOCKS_PER_OP (BLOCKS_PER_OP)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_ch.operation),
    .in_block_number (in_ch.block_number),
    .cfg_ch          (cfg_ch),
    .out_ch          (out_ch),
    .cmd             (dp_cmd),
    .sts             (dp_sts)
  );

endmodule
